>>> hw/rtl/bmu_pkg.sv
// Shared types and constants for the breakpoint match unit.
package bmu_pkg;

  localparam int BREAK_ENTRIES_DEF = 16;
  localparam int ADDR_W            = 16;
  localparam int FUNC_W            = 2;
  localparam int STATUS_W          = 2;
  localparam int Q_DEPTH           = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DEL   = 2'd1,
    FUNC_STEP  = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  // Classified item handed from the front end to the execution side.
  typedef struct packed {
    func_t             op;
    logic              needs_scan;
    logic [ADDR_W-1:0] address;
  } item_t;

  typedef struct packed {
    logic    may_run;
    logic    hit;
    status_t status;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

endpackage

>>> hw/rtl/bmu_if.sv
// Valid/ready channel interfaces for the item and result beats.
interface bmu_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmu_pkg::FUNC_W-1:0]  func;
  logic [bmu_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output func, output address, input ready);
  modport sink   (input valid, input func, input address, output ready);
endinterface

interface bmu_out_if;
  logic                         valid;
  logic                         ready;
  logic                         may_run;
  logic                         hit;
  logic [bmu_pkg::STATUS_W-1:0] status;

  modport source (output valid, output may_run, output hit, output status, input ready);
  modport sink   (input valid, input may_run, input hit, input status, output ready);
endinterface

>>> hw/rtl/breakpoint_match_unit_top.sv
// Top level of the breakpoint match unit: front end, queue and execution side.
//
//  channel   dir  signals                              beat
//  in_chan   in   valid ready func[1:0] address[15:0]  one operation
//  out_chan  out  valid ready may_run hit status[1:0]  one result per operation
//
// Add, delete and query scan the table in the execution side: the addresses sit
// in a single-port memory and are scanned one entry a cycle (read, then compare),
// followed by an execute step. Arm single step skips the scan and only executes.
// The front end adds one register stage; the two-entry queue takes beats until full
// while the execution side is busy or its result waits in the output register.
// Reset (rst_n, synchronous) clears all valid bits, the step flag and the queue;
// entry addresses are left as they are and only read behind a valid bit.
module breakpoint_match_unit_top #(
  parameter int BREAK_ENTRIES = bmu_pkg::BREAK_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bmu_in_if.sink      in_chan,
  bmu_out_if.source   out_chan
);
  import bmu_pkg::*;

  // front end -> queue
  logic  fq_vld;
  logic  fq_rdy;
  item_t fq_item;

  // queue -> execution side
  logic  qb_vld;
  logic  qb_rdy;
  item_t qb_item;

  bmu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .push_vld  (fq_vld),
    .push_rdy  (fq_rdy),
    .push_item (fq_item)
  );

  bmu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (fq_vld),
    .push_rdy  (fq_rdy),
    .push_item (fq_item),
    .pop_vld   (qb_vld),
    .pop_rdy   (qb_rdy),
    .pop_item  (qb_item)
  );

  bmu_back #(
    .BREAK_ENTRIES (BREAK_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_vld  (qb_vld),
    .pop_rdy  (qb_rdy),
    .pop_item (qb_item),
    .out_ch   (out_chan)
  );

endmodule

>>> hw/rtl/bmu_front.sv
// Front end: accepts item beats, classifies them and registers them for the queue.
module bmu_front (
  input  logic           clk,
  input  logic           rst_n,
  bmu_in_if.sink         in_ch,
  output logic           push_vld,
  input  logic           push_rdy,
  output bmu_pkg::item_t push_item
);
  import bmu_pkg::*;

  logic  fr_vld_r;
  item_t fr_item_r;
  item_t cls_item;
  logic  take;

  always_comb begin
    cls_item.op         = func_t'(in_ch.func);
    cls_item.needs_scan = (cls_item.op != FUNC_STEP);
    cls_item.address    = in_ch.address;
  end

  assign in_ch.ready = !fr_vld_r || push_rdy;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (take) begin
      fr_vld_r <= 1'b1;
    end else if (push_rdy) begin
      fr_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= cls_item;
    end
  end

  assign push_vld  = fr_vld_r;
  assign push_item = fr_item_r;

endmodule

>>> hw/rtl/bmu_queue.sv
// Short FIFO decoupling the front end from the execution side.
module bmu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_vld,
  output logic           push_rdy,
  input  bmu_pkg::item_t push_item,
  output logic           pop_vld,
  input  logic           pop_rdy,
  output bmu_pkg::item_t pop_item
);
  import bmu_pkg::*;

  localparam int QW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);
  localparam logic [QW-1:0] Q_LAST = QW'(Q_DEPTH - 1);
  localparam logic [CW-1:0] Q_FULL = CW'(Q_DEPTH);

  item_t          slot_r [Q_DEPTH];
  logic [QW-1:0]  wr_ptr_r;
  logic [QW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_rdy = (cnt_r != Q_FULL);
  assign pop_vld  = (cnt_r != '0);
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/bmu_back.sv
// Execution side: scans the breakpoint table, applies the operation, holds the result.
module bmu_back #(
  parameter int BREAK_ENTRIES = bmu_pkg::BREAK_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_vld,
  output logic           pop_rdy,
  input  bmu_pkg::item_t pop_item,
  bmu_out_if.source      out_ch
);
  import bmu_pkg::*;

  localparam int IW = (BREAK_ENTRIES > 1) ? $clog2(BREAK_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(BREAK_ENTRIES - 1);

  logic [ADDR_W-1:0]        mem [BREAK_ENTRIES];
  logic [ADDR_W-1:0]        rd_data_r;
  logic [BREAK_ENTRIES-1:0] valid_r;
  logic                     step_armed_r;

  state_t                   state_r;
  item_t                    cur_r;
  logic [IW-1:0]            rd_idx_r;
  logic                     issue_r;
  logic [IW-1:0]            cmp_idx_r;
  logic                     cmp_vld_r;
  logic                     match_found_r;
  logic [IW-1:0]            match_idx_r;
  logic                     free_found_r;
  logic [IW-1:0]            free_idx_r;

  logic                     out_vld_r;
  res_t                     res_r;
  res_t                     res_nxt;
  logic                     exec_go;
  logic                     mem_we;
  logic                     ent_hit;
  logic                     ent_free;

  assign pop_rdy  = (state_r == S_IDLE);
  assign exec_go  = (state_r == S_EXEC) && (!out_vld_r || out_ch.ready);
  assign ent_hit  = valid_r[cmp_idx_r] && (rd_data_r == cur_r.address);
  assign ent_free = !valid_r[cmp_idx_r];

  // Result of the current operation from the scan outcome.
  always_comb begin
    res_nxt.may_run = 1'b0;
    res_nxt.hit     = 1'b0;
    res_nxt.status  = ST_OK;
    mem_we          = 1'b0;
    case (cur_r.op)
      FUNC_ADD: begin
        res_nxt.hit = match_found_r;
        if (free_found_r) begin
          mem_we = exec_go;
        end else begin
          res_nxt.status = ST_FULL;
        end
      end
      FUNC_DEL: begin
        if (match_found_r) begin
          res_nxt.hit = 1'b1;
        end else begin
          res_nxt.status = ST_ABSENT;
        end
      end
      FUNC_STEP: begin
      end
      FUNC_QUERY: begin
        if (match_found_r) begin
          res_nxt.hit = 1'b1;
        end else if (!step_armed_r) begin
          res_nxt.may_run = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx_r];
    if (mem_we) begin
      mem[free_idx_r] <= cur_r.address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      step_armed_r  <= 1'b0;
      issue_r       <= 1'b0;
      cmp_vld_r     <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (exec_go) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          cmp_vld_r <= 1'b0;
          if (pop_vld) begin
            match_found_r <= 1'b0;
            free_found_r  <= 1'b0;
            issue_r       <= pop_item.needs_scan;
            state_r       <= pop_item.needs_scan ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          cmp_vld_r <= issue_r;
          if (issue_r && rd_idx_r == LAST) begin
            issue_r <= 1'b0;
          end
          if (cmp_vld_r) begin
            if (ent_hit && !match_found_r) begin
              match_found_r <= 1'b1;
            end
            if (ent_free && !free_found_r) begin
              free_found_r <= 1'b1;
            end
            if (cmp_idx_r == LAST) begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_r <= S_IDLE;
            case (cur_r.op)
              FUNC_ADD: begin
                if (free_found_r) begin
                  valid_r[free_idx_r] <= 1'b1;
                end
              end
              FUNC_DEL: begin
                if (match_found_r) begin
                  valid_r[match_idx_r] <= 1'b0;
                end
              end
              FUNC_STEP: begin
                step_armed_r <= 1'b1;
              end
              FUNC_QUERY: begin
                if (!match_found_r) begin
                  step_armed_r <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop_vld) begin
      cur_r    <= pop_item;
      rd_idx_r <= '0;
    end else if (state_r == S_SCAN && issue_r && rd_idx_r != LAST) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    cmp_idx_r <= rd_idx_r;
    if (cmp_vld_r && ent_hit && !match_found_r) begin
      match_idx_r <= cmp_idx_r;
    end
    if (cmp_vld_r && ent_free && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (exec_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.may_run = res_r.may_run;
  assign out_ch.hit     = res_r.hit;
  assign out_ch.status  = res_r.status;

endmodule

>>> tb/sv/breakpoint_match_unit_top_tb.sv
// Self-checking testbench for the breakpoint match unit top level.
module breakpoint_match_unit_top_tb;
  import bmu_pkg::*;

  localparam int TABLE_DEPTH = BREAK_ENTRIES_DEF;
  localparam int ITEMS       = 1150;
  // Settle time after the last result, covering a scanning op in the execution side
  // plus queue and output register.
  localparam int SETTLE      = 2 * TABLE_DEPTH + 8;
  localparam int IDLE_PCT    = 9;
  // Window of cycles in which neither side idles.
  localparam int QUIET_FROM  = 4000;
  localparam int QUIET_TO    = 9000;

  typedef struct {
    func_t             op;
    logic [ADDR_W-1:0] addr;
    bit                drain;   // hold off until every result is back
  } op_beat_t;

  logic clk;
  logic rst_n;

  bmu_in_if  in_chan();
  bmu_out_if out_chan();

  breakpoint_match_unit_top #(
    .BREAK_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Pending operation beats, and the verdicts still owed by the block.
  op_beat_t pending_ops[$];
  res_t     verdict_q[$];
  op_beat_t next_beat;

  // Shadow of the breakpoint table and the single-step flag.
  logic [ADDR_W-1:0] bp_addr [TABLE_DEPTH];
  logic              bp_live [TABLE_DEPTH];
  logic              step_armed;

  int   n_accepted;
  int   n_results;
  int   mismatches;
  int   cyc;
  logic in_fire;
  logic quiet;

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Verdict for one operation; updates the shadow table as the block should.
  // Hit is taken against the table as it stands before the op acts.
  function automatic res_t predict_verdict(func_t op, logic [ADDR_W-1:0] pc);
    res_t r;
    int   match_idx;
    int   free_idx;
    r.may_run = 1'b0;
    r.hit     = 1'b0;
    r.status  = ST_OK;
    match_idx = -1;
    free_idx  = -1;
    // Walk downwards so the lowest-numbered match and free slot win.
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (bp_live[i] && bp_addr[i] == pc) match_idx = i;
      if (!bp_live[i]) free_idx = i;
    end
    case (op)
      FUNC_ADD: begin
        // Duplicates take a further slot; a full table drops the add.
        r.hit = (match_idx >= 0);
        if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          bp_addr[free_idx] = pc;
          bp_live[free_idx] = 1'b1;
        end
      end
      FUNC_DEL: begin
        if (match_idx < 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.hit              = 1'b1;
          bp_live[match_idx] = 1'b0;
        end
      end
      FUNC_STEP: begin
        step_armed = 1'b1;
      end
      default: begin
        // A breakpoint hit stops without consuming the step flag.
        if (match_idx >= 0) begin
          r.hit = 1'b1;
        end else if (step_armed) begin
          step_armed = 1'b0;
        end else begin
          r.may_run = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void push_op(func_t op, logic [ADDR_W-1:0] a);
    op_beat_t b;
    b.op    = op;
    b.addr  = a;
    b.drain = 1'b0;
    pending_ops.push_back(b);
  endfunction

  function automatic logic [ADDR_W-1:0] any_addr();
    // Bias a little towards the two extremes.
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return ADDR_W'($urandom_range(16'hFFFF));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: predicts at the rising edge where a beat is taken, drives the next
  // beat at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc     <= cyc + 1;
    in_fire <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      verdict_q.push_back(predict_verdict(func_t'(in_chan.func), in_chan.address));
      n_accepted++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_fire) begin
      // Current beat gone (or none shown): idle, hold off, or present the next one.
      if (pending_ops.size() == 0 ||
          (pending_ops[0].drain && verdict_q.size() != 0) ||
          (!quiet && $urandom_range(99) < IDLE_PCT)) begin
        in_chan.valid <= 1'b0;
      end else begin
        next_beat       = pending_ops.pop_front();
        in_chan.valid   <= 1'b1;
        in_chan.func    <= next_beat.op;
        in_chan.address <= next_beat.addr;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, each result beat checked against the oldest
  // outstanding verdict.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_chan.ready <= rst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: may_run=%0b hit=%0b status=%0d",
                   out_chan.may_run, out_chan.hit, out_chan.status);
      end else begin
        if (out_chan.may_run !== verdict_q[0].may_run ||
            out_chan.hit     !== verdict_q[0].hit     ||
            out_chan.status  !== verdict_q[0].status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected may_run=%0b hit=%0b status=%0d, got %0b %0b %0d",
                     n_results, verdict_q[0].may_run, verdict_q[0].hit, verdict_q[0].status,
                     out_chan.may_run, out_chan.hit, out_chan.status);
        end
        void'(verdict_q.pop_front());
      end
      n_results++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0] pool [6];
    logic [ADDR_W-1:0] placed [$];
    logic [ADDR_W-1:0] a;
    func_t             op;
    int                mode;
    int                len;
    int                roll;
    int                idx;
    int                n_directed;

    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.func     = FUNC_ADD;
    in_chan.address  = '0;
    out_chan.ready   = 1'b0;
    cyc              = 0;
    in_fire          = 1'b0;
    n_accepted       = 0;
    n_results        = 0;
    mismatches       = 0;
    step_armed       = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      bp_live[i] = 1'b0;
      bp_addr[i] = '0;
    end

    // Directed: empty table, extremes, duplicates, step flag behaviour.
    push_op(FUNC_QUERY, 16'h0000);   // empty table, runs
    push_op(FUNC_DEL,   16'hFFFF);   // absent
    push_op(FUNC_ADD,   16'h0000);
    push_op(FUNC_ADD,   16'hFFFF);
    push_op(FUNC_ADD,   16'hFFFF);   // duplicate takes a further slot
    push_op(FUNC_QUERY, 16'hFFFF);   // hit
    push_op(FUNC_STEP,  16'h1234);
    push_op(FUNC_STEP,  16'hABCD);   // arm while armed
    push_op(FUNC_QUERY, 16'h0000);   // hit, flag stays armed
    push_op(FUNC_QUERY, 16'h5555);   // miss, step consumed
    push_op(FUNC_QUERY, 16'h5555);   // runs again
    push_op(FUNC_DEL,   16'hFFFF);   // frees lowest of the pair
    push_op(FUNC_QUERY, 16'hFFFF);   // still hit
    push_op(FUNC_DEL,   16'hFFFF);
    push_op(FUNC_DEL,   16'hFFFF);   // now absent
    push_op(FUNC_DEL,   16'h0000);
    push_op(FUNC_QUERY, 16'hFFFF);
    n_directed = pending_ops.size();

    // Random: episodes that fill, drain or mix, mostly over a small address pool
    // so that hits, duplicates and a full table come up often.
    while (pending_ops.size() < ITEMS) begin
      mode = $urandom_range(3);
      for (int k = 0; k < 6; k++)
        pool[k] = (placed.size() > 0 && $urandom_range(1)) ?
                  placed[$urandom_range(placed.size() - 1)] : any_addr();
      len = $urandom_range(45, 15);
      for (int j = 0; j < len; j++) begin
        roll = $urandom_range(99);
        a    = ($urandom_range(4) == 0) ? any_addr() : pool[$urandom_range(5)];
        case (mode)
          0:       op = roll < 65 ? FUNC_ADD : roll < 75 ? FUNC_DEL :
                        roll < 85 ? FUNC_STEP : FUNC_QUERY;
          1:       op = roll < 15 ? FUNC_ADD : roll < 65 ? FUNC_DEL :
                        roll < 75 ? FUNC_STEP : FUNC_QUERY;
          default: op = roll < 20 ? FUNC_ADD : roll < 40 ? FUNC_DEL :
                        roll < 50 ? FUNC_STEP : FUNC_QUERY;
        endcase
        // About half of the deletes target something added earlier, so the table empties.
        if (op == FUNC_DEL && placed.size() > 0 && roll[0]) begin
          idx = $urandom_range(placed.size() - 1);
          a   = placed[idx];
          placed.delete(idx);
        end
        if (op == FUNC_ADD) begin
          placed.push_back(a);
          if (placed.size() > 64) void'(placed.pop_front());
        end
        push_op(op, a);
      end
    end
    // Sender holds off until the block has emptied, twice.
    pending_ops[n_directed].drain = 1'b1;
    pending_ops[ITEMS / 2].drain  = 1'b1;
    n_directed = pending_ops.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_directed) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
